/* rtl/core/hgp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hgp_pkg;

  // Default widths of the length prefix and the list depth counter.
  localparam int LENGTH_BITS_DEF = 16;
  localparam int DEPTH_BITS_DEF  = 8;

  // Queue between the parser and the output side.
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = 2;

  // Byte codes the parser reacts to.
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_VERSION = 3'd1,
    PH_CAPS    = 3'd2,
    PH_URL     = 3'd3,
    PH_AGENT   = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_VERSION  = 3'd0,
    KIND_CAP_BYTE = 3'd1,
    KIND_CAP_END  = 3'd2,
    KIND_URL_BYTE = 3'd3,
    KIND_AGT_BYTE = 3'd4,
    KIND_STATUS   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_URL_OVER  = 2'd1,
    ST_AGT_OVER  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  // One result beat.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
  } res_t;

  // All results caused by one input byte: one or two.
  typedef struct packed {
    logic two;
    res_t r1;
    res_t r0;
  } rec_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

/* rtl/core/handshake_greeting_parser.sv */
// A result group is written into the queue; each result beat then passes through the output register.
// Throughput: one input byte per cycle while the queue is not full; a byte with two results (the last
// byte of a message that also yields a data result) goes out as two output beats, and the
// four-entry queue between parser and output register absorbs that.
// Reset: synchronous, active-low rst_n clears parser state, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module handshake_greeting_parser #(
  parameter int LENGTH_BITS = hgp_pkg::LENGTH_BITS_DEF,
  parameter int DEPTH_BITS  = hgp_pkg::DEPTH_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] in_byte
  input  wire         in_tlast,   // is_last
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [7:0] data, [9:8] status, [15:10] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // end_of_run
);

  hgp_pkg::fifo_stat_t stat;
  hgp_pkg::rec_t       push_rec, head_rec;
  hgp_pkg::res_t       out_res;
  logic                push, pop;

  // Front: byte parser.
  hgp_front #(
    .LENGTH_BITS(LENGTH_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .stat    (stat),
    .push    (push),
    .push_rec(push_rec)
  );

  // Queue of per-byte result groups.
  hgp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .head_rec(head_rec),
    .stat    (stat)
  );

  // Back: serializes results into the output register.
  hgp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_rec (head_rec),
    .stat     (stat),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res),
    .out_last (out_tlast)
  );

  assign out_tdata = {6'b0, out_res.status, out_res.data};
  assign out_tuser = out_res.kind;

  // The queue cannot be full and empty at once.
  assert property (@(posedge clk) disable iff (!rst_n) !(stat.full && stat.empty))
    else $error("queue full and empty together");

  // A last byte always leaves a status group in the queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !stat.empty)
    else $error("last byte produced no queue entry");

  // A status beat always closes its byte's run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == hgp_pkg::KIND_STATUS)) |-> out_tlast)
    else $error("status beat without end of run");

  // Non-status beats carry a zero status field.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != hgp_pkg::KIND_STATUS)) |-> (out_tdata[9:8] == 2'b00))
    else $error("status set on a data beat");

endmodule

`default_nettype wire

/* rtl/core/hgp_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module hgp_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  hgp_pkg::rec_t    push_rec,
  input  wire              pop,
  output hgp_pkg::rec_t    head_rec,
  output hgp_pkg::fifo_stat_t stat
);

  hgp_pkg::rec_t mem_r [hgp_pkg::FIFO_DEPTH];
  logic [hgp_pkg::FIFO_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hgp_pkg::FIFO_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hgp_pkg::FIFO_PTR_BITS:0]   cnt_r, cnt_nxt;
  logic do_push, do_pop;

  // Status and head entry.
  assign stat = '{
    full:  (cnt_r == (hgp_pkg::FIFO_PTR_BITS+1)'(hgp_pkg::FIFO_DEPTH)),
    empty: (cnt_r == '0)
  };
  assign head_rec   = mem_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  // Pointer and count updates.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hgp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module hgp_front #(
  parameter int LENGTH_BITS = hgp_pkg::LENGTH_BITS_DEF,
  parameter int DEPTH_BITS  = hgp_pkg::DEPTH_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_byte,
  input  wire                 in_last,
  input  hgp_pkg::fifo_stat_t stat,
  output logic                push,
  output hgp_pkg::rec_t       push_rec
);

  localparam int MW = LENGTH_BITS + 4;

  logic [DEPTH_BITS-1:0]  depth_r, depth_nxt;
  hgp_pkg::phase_t        phase_r, phase_nxt;
  logic                   caps_seen_r, caps_seen_nxt;
  logic                   word_has_r, word_has_nxt;
  logic [LENGTH_BITS-1:0] accum_r, accum_nxt;
  logic [LENGTH_BITS:0]   remain_r, remain_nxt;
  logic                   copying_r, copying_nxt;
  logic                   url_ne_r, url_ne_nxt;

  logic          accept;
  logic          blank, digit;
  logic          body_vld;
  hgp_pkg::res_t body_res, stat_res;
  logic [MW-1:0] acc_ext, acc_mul;

  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;

  assign blank = (in_byte == hgp_pkg::CH_SPACE) || (in_byte == hgp_pkg::CH_LF);
  assign digit = (in_byte >= hgp_pkg::CH_ZERO) && (in_byte <= hgp_pkg::CH_NINE);

  // Decimal prefix step: accum * 10 + digit, as two shifts and adds.
  assign acc_ext = {4'b0, accum_r};
  assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + {{(MW-4){1'b0}}, in_byte[3:0]};

  // Parser state update and result forming for one byte.
  always_comb begin
    depth_nxt     = depth_r;
    phase_nxt     = phase_r;
    caps_seen_nxt = caps_seen_r;
    word_has_nxt  = word_has_r;
    accum_nxt     = accum_r;
    remain_nxt    = remain_r;
    copying_nxt   = copying_r;
    url_ne_nxt    = url_ne_r;
    body_vld      = 1'b0;
    body_res      = '{kind: hgp_pkg::KIND_VERSION, data: 8'h00, status: hgp_pkg::ST_OK};
    stat_res      = '{kind: hgp_pkg::KIND_STATUS, data: 8'h00, status: hgp_pkg::ST_OK};

    if (copying_r) begin
      // Inside a string: pass bytes, the final counted byte is swallowed.
      if (remain_r > (LENGTH_BITS+1)'(1)) begin
        body_vld      = 1'b1;
        body_res.kind = (phase_r == hgp_pkg::PH_URL) ? hgp_pkg::KIND_URL_BYTE
                                                     : hgp_pkg::KIND_AGT_BYTE;
        body_res.data = in_byte;
      end
      remain_nxt = remain_r - 1'b1;
      if (remain_r == (LENGTH_BITS+1)'(1)) begin
        copying_nxt = 1'b0;
        phase_nxt   = (phase_r == hgp_pkg::PH_URL) ? hgp_pkg::PH_AGENT : hgp_pkg::PH_DONE;
        accum_nxt   = '0;
      end
    end else if (in_byte == hgp_pkg::CH_OPEN) begin
      depth_nxt = depth_r + 1'b1;
      if (depth_nxt == DEPTH_BITS'(2)) begin
        caps_seen_nxt = 1'b1;
      end
    end else if (in_byte == hgp_pkg::CH_CLOSE) begin
      depth_nxt = depth_r - 1'b1;
    end else begin
      // A blank closes a capability word that has bytes.
      if (blank && (phase_r == hgp_pkg::PH_CAPS) && word_has_r) begin
        body_vld      = 1'b1;
        body_res.kind = hgp_pkg::KIND_CAP_END;
        word_has_nxt  = 1'b0;
      end
      unique case (phase_r)
        hgp_pkg::PH_WAIT: begin
          if (depth_r == DEPTH_BITS'(1)) begin
            phase_nxt = hgp_pkg::PH_VERSION;
          end
        end
        hgp_pkg::PH_VERSION: begin
          if (digit) begin
            body_vld      = 1'b1;
            body_res.kind = hgp_pkg::KIND_VERSION;
            body_res.data = {4'b0, in_byte[3:0]};
          end
          phase_nxt = hgp_pkg::PH_CAPS;
        end
        hgp_pkg::PH_CAPS: begin
          if (caps_seen_r && (depth_r == DEPTH_BITS'(1))) begin
            phase_nxt = hgp_pkg::PH_URL;
            accum_nxt = '0;
          end else if (!blank) begin
            body_vld      = 1'b1;
            body_res.kind = hgp_pkg::KIND_CAP_BYTE;
            body_res.data = in_byte;
            word_has_nxt  = 1'b1;
          end
        end
        hgp_pkg::PH_URL, hgp_pkg::PH_AGENT: begin
          if (in_byte != hgp_pkg::CH_SPACE) begin
            if (digit) begin
              if (acc_mul[MW-1:LENGTH_BITS] != '0) begin
                accum_nxt = '1;
              end else begin
                accum_nxt = acc_mul[LENGTH_BITS-1:0];
              end
            end else begin
              // Any other byte ends the prefix and opens the string.
              if ((phase_r == hgp_pkg::PH_URL) && (accum_r != '0)) begin
                url_ne_nxt = 1'b1;
              end
              remain_nxt  = {1'b0, accum_r} + 1'b1;
              copying_nxt = 1'b1;
              accum_nxt   = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Final status on the last byte, then back to the idle state.
    if (in_last) begin
      priority if (copying_nxt) begin
        stat_res.status = (phase_nxt == hgp_pkg::PH_URL) ? hgp_pkg::ST_URL_OVER
                                                         : hgp_pkg::ST_AGT_OVER;
      end else if ((depth_nxt != '0) || !url_ne_nxt) begin
        stat_res.status = hgp_pkg::ST_MALFORMED;
      end else begin
        stat_res.status = hgp_pkg::ST_OK;
      end
      depth_nxt     = '0;
      phase_nxt     = hgp_pkg::PH_WAIT;
      caps_seen_nxt = 1'b0;
      word_has_nxt  = 1'b0;
      accum_nxt     = '0;
      remain_nxt    = '0;
      copying_nxt   = 1'b0;
      url_ne_nxt    = 1'b0;
    end

    // Pack the beat's results for the queue.
    push         = accept && (body_vld || in_last);
    push_rec.two = body_vld && in_last;
    push_rec.r0  = body_vld ? body_res : stat_res;
    push_rec.r1  = stat_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      phase_r     <= hgp_pkg::PH_WAIT;
      caps_seen_r <= 1'b0;
      word_has_r  <= 1'b0;
      accum_r     <= '0;
      remain_r    <= '0;
      copying_r   <= 1'b0;
      url_ne_r    <= 1'b0;
    end else if (accept) begin
      depth_r     <= depth_nxt;
      phase_r     <= phase_nxt;
      caps_seen_r <= caps_seen_nxt;
      word_has_r  <= word_has_nxt;
      accum_r     <= accum_nxt;
      remain_r    <= remain_nxt;
      copying_r   <= copying_nxt;
      url_ne_r    <= url_ne_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hgp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module hgp_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  hgp_pkg::rec_t       head_rec,
  input  hgp_pkg::fifo_stat_t stat,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output hgp_pkg::res_t       out_res,
  output logic                out_last
);

  logic          valid_r, valid_nxt;
  logic          idx_r, idx_nxt;
  hgp_pkg::res_t res_r, res_nxt;
  logic          last_r, last_nxt;
  logic          load, rec_done;
  hgp_pkg::res_t sel_res;

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

  // The output register refills when empty or when its beat is taken.
  assign load     = !valid_r || out_ready;
  assign sel_res  = idx_r ? head_rec.r1 : head_rec.r0;
  assign rec_done = idx_r || !head_rec.two;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !stat.empty;
      if (!stat.empty) begin
        res_nxt  = sel_res;
        last_nxt = rec_done;
        pop      = rec_done;
        idx_nxt  = !rec_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire
